// File: rtl/core/tse_pkg.sv
// Shared widths, defaults and function codes of the Taylor series evaluator.
`timescale 1ns / 1ps

package tse_pkg;

    localparam int SEL_W = 2;
    localparam int X_W   = 32;
    localparam int CNT_W = 5;
    localparam int SUM_W = 48;

    localparam int DEF_MAX_TERMS = 31;
    localparam int DEF_FRAC_BITS = 24;

    // Largest magnitudes a term or a sum may take, for each sign.
    localparam logic [SUM_W-1:0] POS_CAP = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] NEG_CAP = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [SEL_W-1:0] {
        FN_SIN  = 2'd0,
        FN_COS  = 2'd1,
        FN_LN1P = 2'd2,
        FN_EXP  = 2'd3
    } func_sel_t;

endpackage

// File: rtl/core/tse_if.sv
// Valid/ready channel interfaces for the argument and result transactions.
`timescale 1ns / 1ps

interface tse_in_if import tse_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SEL_W-1:0]        function_select;
    logic signed [X_W-1:0]   x_value;
    logic [CNT_W-1:0]        term_count;

    modport source (output valid, output function_select, output x_value,
                    output term_count, input ready);
    modport sink   (input valid, input function_select, input x_value,
                    input term_count, output ready);
endinterface

interface tse_out_if import tse_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] series_sum;
    logic                    overflow;

    modport source (output valid, output series_sum, output overflow, input ready);
    modport sink   (input valid, input series_sum, input overflow, output ready);
endinterface

// File: rtl/core/taylor_series_evaluator.sv
// Evaluates term 0 plus n further terms (n = 0 gives term 0 alone), with
// MW = max(63 - FRAC_BITS, 32 + clog2(MAX_TERMS + 1)) as the multiplier operand width.
// Throughput: one transaction at a time; the bit-serial shift-add multiplier and the
// bit-serial restoring divider, one bit per cycle each, set the cost of every term.
// A new argument is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps

module taylor_series_evaluator import tse_pkg::*; #(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    tse_in_if.sink     in_ch,
    tse_out_if.source  out_ch
);

    // Term index width, largest divisor and its width.
    localparam int IW   = $clog2(MAX_TERMS + 1);
    localparam int DMAX = 2 * MAX_TERMS * (2 * MAX_TERMS + 1);
    localparam int DW   = $clog2(DMAX + 1);
    // Width of the multiplier operand: x squared (sin, cos) or |x| * i (ln).
    localparam int SQW  = 63 - FRAC_BITS;
    localparam int LNW  = X_W + IW;
    localparam int MW   = (SQW > LNW) ? SQW : LNW;
    // Product width and number of quotient bits produced per term.
    localparam int PW   = SUM_W + MW;
    localparam int DIVN = PW - FRAC_BITS;
    localparam int CW   = $clog2(DIVN + 1);

    localparam logic [SUM_W-1:0] FX_ONE = SUM_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SQ_LOAD,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t            state_reg,     state_next;
    func_sel_t         sel_reg,       sel_next;
    logic              xneg_reg,      xneg_next;
    logic [X_W-1:0]    xmag_reg,      xmag_next;
    logic [IW-1:0]     n_reg,         n_next;
    logic [IW-1:0]     i_reg,         i_next;
    logic [MW-1:0]     xsq_reg,       xsq_next;
    logic [MW-1:0]     lnm_reg,       lnm_next;
    logic [SUM_W-1:0]  t_reg,         t_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;
    logic              ovf_reg,       ovf_next;
    logic [SUM_W-1:0]  mcand_reg,     mcand_next;
    logic [DW-1:0]     d_reg,         d_next;
    logic              neg_reg,       neg_next;
    logic [PW-1:0]     prod_reg,      prod_next;
    logic [CW-1:0]     cnt_reg,       cnt_next;
    logic [DW-1:0]     rem_reg,       rem_next;
    logic [SUM_W-1:0]  q_reg,         q_next;
    logic              qov_reg,       qov_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  out_sum_reg,   out_sum_next;
    logic              out_ovf_reg,   out_ovf_next;

    // Argument decode at the input port.
    logic [X_W-1:0]    in_x;
    logic [X_W-1:0]    in_xmag;
    logic [IW-1:0]     in_n;
    logic [SUM_W-1:0]  in_t0;
    func_sel_t         in_sel;

    // One step of the shift-add multiplier: the low end of the product register holds
    // the remaining multiplier bits, the high end accumulates the partial product.
    logic [SUM_W:0]    mul_acc;
    logic [PW-1:0]     mul_prod;

    // One step of the restoring divider, fed from the top bit of the product register.
    logic [DW:0]       div_cur;
    logic [DW-1:0]     div_diff;
    logic              div_ge;
    logic [DW-1:0]     div_rem;

    // Term rescaling setup.
    logic [SUM_W-1:0]  t_mag_cur;
    logic              flip;
    logic [MW-1:0]     lnm_sum;
    logic [MW-1:0]     m_sel;
    logic [DW-1:0]     i_d;
    logic [DW-1:0]     two_i;
    logic [DW-1:0]     d_sel;

    // Term saturation and accumulation.
    logic [SUM_W-1:0]  term_cap;
    logic              term_sat;
    logic [SUM_W-1:0]  term_mag;
    logic [SUM_W-1:0]  term_new;
    logic [SUM_W:0]    sum_wide;
    logic              sum_hi;
    logic              sum_lo;
    logic [SUM_W-1:0]  sum_new;

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.series_sum = out_sum_reg;
    assign out_ch.overflow   = out_ovf_reg;

    always_comb
    begin
        in_x    = in_ch.x_value;
        in_xmag = in_x[X_W-1] ? (X_W'(0) - in_x) : in_x;
        in_sel  = func_sel_t'(in_ch.function_select);
        if (int'(in_ch.term_count) > MAX_TERMS)
        begin
            in_n = IW'(MAX_TERMS);
        end
        else
        begin
            in_n = IW'(in_ch.term_count);
        end
        // Sine and ln(1+x) start from x, cosine and exp from one.
        if ((in_sel == FN_SIN) || (in_sel == FN_LN1P))
        begin
            in_t0 = {{(SUM_W-X_W){in_x[X_W-1]}}, in_x};
        end
        else
        begin
            in_t0 = FX_ONE;
        end
    end

    always_comb
    begin
        mul_acc  = {1'b0, prod_reg[PW-1 -: SUM_W]}
                 + (prod_reg[0] ? {1'b0, mcand_reg} : {(SUM_W+1){1'b0}});
        mul_prod = {mul_acc, prod_reg[MW-1:1]};

        // The remainder stays below the divisor, so the low bits of the difference suffice.
        div_cur  = {rem_reg, prod_reg[PW-1]};
        div_diff = div_cur[DW-1:0] - d_reg;
        div_ge   = (div_cur >= {1'b0, d_reg});
        div_rem  = div_ge ? div_diff : div_cur[DW-1:0];
    end

    always_comb
    begin
        t_mag_cur = t_reg[SUM_W-1] ? (SUM_W'(0) - t_reg) : t_reg;
        lnm_sum   = lnm_reg + MW'(xmag_reg);
        i_d       = DW'(i_reg);
        two_i     = i_d << 1;
        case (sel_reg)
            FN_SIN:
            begin
                flip  = 1'b1;
                m_sel = xsq_reg;
                d_sel = two_i * (two_i + DW'(1));
            end
            FN_COS:
            begin
                flip  = 1'b1;
                m_sel = xsq_reg;
                d_sel = two_i * (two_i - DW'(1));
            end
            FN_LN1P:
            begin
                flip  = ~xneg_reg;
                m_sel = lnm_sum;
                d_sel = i_d + DW'(1);
            end
            FN_EXP:
            begin
                flip  = xneg_reg;
                m_sel = MW'(xmag_reg);
                d_sel = i_d;
            end
            default:
            begin
                flip  = 1'b0;
                m_sel = '0;
                d_sel = DW'(1);
            end
        endcase
    end

    always_comb
    begin
        // A quotient that spilled past the term width, or exceeds the cap, saturates.
        term_cap = neg_reg ? NEG_CAP : POS_CAP;
        term_sat = qov_reg | (q_reg > term_cap);
        term_mag = term_sat ? term_cap : q_reg;
        term_new = neg_reg ? (SUM_W'(0) - term_mag) : term_mag;

        sum_wide = {sum_reg[SUM_W-1], sum_reg} + {term_new[SUM_W-1], term_new};
        sum_hi   = ~sum_wide[SUM_W] & sum_wide[SUM_W-1];
        sum_lo   = sum_wide[SUM_W] & ~sum_wide[SUM_W-1];
        if (sum_hi)
        begin
            sum_new = POS_CAP;
        end
        else if (sum_lo)
        begin
            sum_new = NEG_CAP;
        end
        else
        begin
            sum_new = sum_wide[SUM_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        xneg_next      = xneg_reg;
        xmag_next      = xmag_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        xsq_next       = xsq_reg;
        lnm_next       = lnm_reg;
        t_next         = t_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        mcand_next     = mcand_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        qov_next       = qov_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    sel_next   = in_sel;
                    xneg_next  = in_x[X_W-1];
                    xmag_next  = in_xmag;
                    n_next     = in_n;
                    i_next     = IW'(1);
                    lnm_next   = '0;
                    t_next     = in_t0;
                    sum_next   = in_t0;
                    ovf_next   = 1'b0;
                    // Square |x| first; only sine and cosine use it.
                    mcand_next = SUM_W'(in_xmag);
                    prod_next  = PW'(in_xmag);
                    cnt_next   = '0;
                    state_next = (in_n == '0) ? S_FINISH : S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    state_next = S_SQ_LOAD;
                end
            end
            S_SQ_LOAD:
            begin
                xsq_next   = prod_reg[FRAC_BITS +: MW];
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                mcand_next = t_mag_cur;
                neg_next   = t_reg[SUM_W-1] ^ flip;
                d_next     = d_sel;
                prod_next  = PW'(m_sel);
                lnm_next   = lnm_sum;
                rem_next   = '0;
                q_next     = '0;
                qov_next   = 1'b0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                prod_next = prod_reg << 1;
                rem_next  = div_rem;
                q_next    = {q_reg[SUM_W-2:0], div_ge};
                qov_next  = qov_reg | q_reg[SUM_W-1];
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIVN - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                t_next   = term_new;
                sum_next = sum_new;
                ovf_next = ovf_reg | term_sat | sum_hi | sum_lo;
                if (i_reg == n_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_SETUP;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= FN_SIN;
            xneg_reg      <= 1'b0;
            xmag_reg      <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            xsq_reg       <= '0;
            lnm_reg       <= '0;
            t_reg         <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            mcand_reg     <= '0;
            d_reg         <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            qov_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            xneg_reg      <= xneg_next;
            xmag_reg      <= xmag_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            xsq_reg       <= xsq_next;
            lnm_reg       <= lnm_next;
            t_reg         <= t_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            mcand_reg     <= mcand_next;
            d_reg         <= d_next;
            neg_reg       <= neg_next;
            prod_reg      <= prod_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            qov_reg       <= qov_next;
            out_valid_reg <= out_valid_next;
            out_sum_reg   <= out_sum_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

endmodule
